// ===== design/tafc_pkg.sv =====
// Shared widths, constants and helper functions of the torso attitude classifier.
// No dependencies.
`default_nettype none
package tafc_pkg;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TABLE_LEN = 24;
    localparam int VEC_W = 30;
    localparam int ANG_W = 26;
    localparam int OUT_W = 16;
    localparam int LIM_W = 15;
    localparam int GAIN_W = 18;
    localparam logic signed [GAIN_W-1:0] GAIN_Q16 = 18'sd107922;
    localparam logic signed [ANG_W-1:0] DEG180_Z = 26'sd11796480;
    localparam logic signed [17:0] ANG_LIMIT = 18'sd23040;
    localparam logic [LIM_W-1:0] LIMIT_RESET = 15'd7680;
    localparam logic [2:0] ADDR_PITCH_LIMIT = 3'd0;
    localparam logic [2:0] ADDR_ROLL_LIMIT = 3'd4;

    typedef struct packed {
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic signed [15:0] right_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
        logic signed [15:0] fwd_x;
        logic signed [15:0] fwd_y;
        logic signed [15:0] fwd_z;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] yaw_angle;
        logic signed [OUT_W-1:0] pitch_angle;
        logic signed [OUT_W-1:0] roll_angle;
        logic on_back;
        logic on_belly;
        logic on_side;
    } out_item_t;

    typedef struct packed {
        logic [LIM_W-1:0] pitch_fall_limit;
        logic [LIM_W-1:0] roll_fall_limit;
    } limits_t;

    function automatic logic signed [ANG_W-1:0] atan_q16(input int idx);
        logic signed [ANG_W-1:0] r;
        begin
            case (idx)
                0: r = 26'sd2949120;
                1: r = 26'sd1740967;
                2: r = 26'sd919879;
                3: r = 26'sd466945;
                4: r = 26'sd234379;
                5: r = 26'sd117304;
                6: r = 26'sd58666;
                7: r = 26'sd29335;
                8: r = 26'sd14668;
                9: r = 26'sd7334;
                10: r = 26'sd3667;
                11: r = 26'sd1833;
                12: r = 26'sd917;
                13: r = 26'sd458;
                14: r = 26'sd229;
                15: r = 26'sd115;
                16: r = 26'sd57;
                17: r = 26'sd29;
                18: r = 26'sd14;
                19: r = 26'sd7;
                20: r = 26'sd4;
                21: r = 26'sd2;
                22: r = 26'sd1;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [OUT_W-1:0] to_out(input logic signed [ANG_W-1:0] z);
        logic signed [ANG_W:0] s;
        logic signed [17:0] a;
        logic signed [OUT_W-1:0] r;
        begin
            s = ANG_W'(z) + (ANG_W+1)'(256);
            s = $signed({z[ANG_W-1], z}) + $signed((ANG_W+1)'(256));
            a = 18'(s >>> 9);
            if (a > ANG_LIMIT)
                r = OUT_W'(ANG_LIMIT);
            else if (a < -ANG_LIMIT)
                r = OUT_W'(-ANG_LIMIT);
            else
                r = a[OUT_W-1:0];
            return r;
        end
    endfunction
endpackage
`default_nettype wire

// ===== design/tafc_in_if.sv =====
// Input channel: valid/ready handshake carrying one rotation matrix.
// Depends on tafc_pkg.
`default_nettype none
interface tafc_in_if;
    logic valid;
    logic ready;
    tafc_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/tafc_out_if.sv =====
// Output channel: valid/ready handshake carrying angles and fall flags.
// Depends on tafc_pkg.
`default_nettype none
interface tafc_out_if;
    logic valid;
    logic ready;
    tafc_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/tafc_cordic.sv =====
// Pipelined vectoring CORDIC: one pre-rotation stage, then one stage per step.
// Vector 0 steers; the other vectors follow. Depends on tafc_pkg.
`default_nettype none
module tafc_cordic #(
    parameter int STEPS = tafc_pkg::CORDIC_STEPS_DEF,
    parameter int NV = 1
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  wire logic in_valid,
    input  wire logic signed [tafc_pkg::VEC_W-1:0] in_x [NV],
    input  wire logic signed [tafc_pkg::VEC_W-1:0] in_y [NV],
    output logic out_valid,
    output logic signed [tafc_pkg::VEC_W-1:0] out_x [NV],
    output logic signed [tafc_pkg::VEC_W-1:0] out_y [NV],
    output logic signed [tafc_pkg::ANG_W-1:0] out_z
);
    localparam int NS = (STEPS > tafc_pkg::TABLE_LEN) ? tafc_pkg::TABLE_LEN : STEPS;
    localparam int W = tafc_pkg::VEC_W;
    localparam int ZW = tafc_pkg::ANG_W;

    logic signed [W-1:0] x_reg [NS+1][NV];
    logic signed [W-1:0] y_reg [NS+1][NV];
    logic signed [ZW-1:0] z_reg [NS+1];
    logic zero_reg [NS+1];
    logic vld_reg [NS+1];

    // pre-rotation by 180 degrees for the left half plane
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (in_x[0] == '0) && (in_y[0] == '0);
            if (in_x[0] < 0)
            begin
                z_reg[0] <= (in_y[0] >= 0) ? tafc_pkg::DEG180_Z : -tafc_pkg::DEG180_Z;
                for (int k = 0; k < NV; k++)
                begin
                    x_reg[0][k] <= -in_x[k];
                    y_reg[0][k] <= -in_y[k];
                end
            end
            else
            begin
                z_reg[0] <= '0;
                for (int k = 0; k < NV; k++)
                begin
                    x_reg[0][k] <= in_x[k];
                    y_reg[0][k] <= in_y[k];
                end
            end
        end
    end

    for (genvar s = 0; s < NS; s++)
    begin : g_step
        logic signed [W-1:0] x_next [NV];
        logic signed [W-1:0] y_next [NV];
        logic signed [ZW-1:0] z_next;

        always_comb
        begin
            if (zero_reg[s])
            begin
                z_next = z_reg[s];
                for (int k = 0; k < NV; k++)
                begin
                    x_next[k] = x_reg[s][k];
                    y_next[k] = y_reg[s][k];
                end
            end
            else if (y_reg[s][0] >= 0)
            begin
                z_next = z_reg[s] + tafc_pkg::atan_q16(s);
                for (int k = 0; k < NV; k++)
                begin
                    x_next[k] = x_reg[s][k] + (y_reg[s][k] >>> s);
                    y_next[k] = y_reg[s][k] - (x_reg[s][k] >>> s);
                end
            end
            else
            begin
                z_next = z_reg[s] - tafc_pkg::atan_q16(s);
                for (int k = 0; k < NV; k++)
                begin
                    x_next[k] = x_reg[s][k] - (y_reg[s][k] >>> s);
                    y_next[k] = y_reg[s][k] + (x_reg[s][k] >>> s);
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s+1] <= 1'b0;
            else if (en)
                vld_reg[s+1] <= vld_reg[s];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[s+1] <= zero_reg[s];
                z_reg[s+1] <= z_next;
                for (int k = 0; k < NV; k++)
                begin
                    x_reg[s+1][k] <= x_next[k];
                    y_reg[s+1][k] <= y_next[k];
                end
            end
        end
    end

    assign out_valid = vld_reg[NS];
    assign out_x = x_reg[NS];
    assign out_y = y_reg[NS];
    assign out_z = z_reg[NS];
endmodule
`default_nettype wire

// ===== design/tafc_apb.sv =====
// APB register block holding the pitch and roll fall limits.
// Depends on tafc_pkg.
`default_nettype none
module tafc_apb (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic psel,
    input  wire logic penable,
    input  wire logic pwrite,
    input  wire logic [2:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready,
    output tafc_pkg::limits_t limits
);
    tafc_pkg::limits_t lim_reg;
    logic wr;

    assign wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign limits = lim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg.pitch_fall_limit <= tafc_pkg::LIMIT_RESET;
            lim_reg.roll_fall_limit <= tafc_pkg::LIMIT_RESET;
        end
        else if (wr)
        begin
            if (paddr[2] == tafc_pkg::ADDR_ROLL_LIMIT[2])
                lim_reg.roll_fall_limit <= pwdata[tafc_pkg::LIM_W-1:0];
            else
                lim_reg.pitch_fall_limit <= pwdata[tafc_pkg::LIM_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr == tafc_pkg::ADDR_PITCH_LIMIT)
            prdata = 32'(lim_reg.pitch_fall_limit);
        else if (paddr == tafc_pkg::ADDR_ROLL_LIMIT)
            prdata = 32'(lim_reg.roll_fall_limit);
        else
            prdata = '0;
    end
endmodule
`default_nettype wire

// ===== design/torso_attitude_fall_classifier.sv =====
// Throughput one transfer per cycle while the output register is empty or being taken;
// CORDIC steps are capped at 24.
// Yaw CORDIC, gain multiply stage, parallel pitch and roll CORDICs, angle stage, output register.
// The whole pipeline holds while the output register is full and not taken.
// Reset (rst_n, async, active low) clears all valid bits; limits return to 60 degrees.
// Depends on tafc_pkg, tafc_in_if, tafc_out_if, tafc_cordic, tafc_apb.
`default_nettype none
module torso_attitude_fall_classifier #(
    parameter int CORDIC_STEPS = tafc_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    tafc_in_if.sink item_in,
    tafc_out_if.source result_out,
    input  wire logic psel,
    input  wire logic penable,
    input  wire logic pwrite,
    input  wire logic [2:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready
);
    localparam int NS = (CORDIC_STEPS > tafc_pkg::TABLE_LEN) ? tafc_pkg::TABLE_LEN
                                                            : CORDIC_STEPS;
    localparam int W = tafc_pkg::VEC_W;
    localparam int ZW = tafc_pkg::ANG_W;
    localparam int OW = tafc_pkg::OUT_W;
    localparam int PW = 25 + tafc_pkg::GAIN_W;

    tafc_pkg::limits_t limits;
    logic en;

    logic signed [W-1:0] yin_x [3];
    logic signed [W-1:0] yin_y [3];
    logic y_vld;
    logic signed [W-1:0] y_x [3];
    logic signed [W-1:0] y_y [3];
    logic signed [ZW-1:0] y_z;
    logic signed [23:0] rz_dly_reg [NS+1];

    logic m_vld_reg;
    logic signed [W-1:0] px_reg;
    logic signed [W-1:0] py_reg;
    logic signed [W-1:0] qx_reg;
    logic signed [W-1:0] qy_reg;
    logic signed [OW-1:0] yaw_m_reg;
    logic signed [24:0] nrz;
    logic signed [PW-1:0] prod;

    logic signed [W-1:0] pin_x [1];
    logic signed [W-1:0] pin_y [1];
    logic signed [W-1:0] rin_x [1];
    logic signed [W-1:0] rin_y [1];
    logic p_vld;
    logic r_vld;
    logic signed [W-1:0] p_x [1];
    logic signed [W-1:0] p_y [1];
    logic signed [W-1:0] r_x [1];
    logic signed [W-1:0] r_y [1];
    logic signed [ZW-1:0] p_z;
    logic signed [ZW-1:0] r_z;
    logic signed [OW-1:0] yaw_dly_reg [NS+1];

    logic a_vld_reg;
    logic signed [OW-1:0] yaw_a_reg;
    logic signed [OW-1:0] pitch_a_reg;
    logic signed [OW-1:0] roll_a_reg;

    logic out_vld_reg;
    tafc_pkg::out_item_t out_reg;
    tafc_pkg::out_item_t out_next;
    logic signed [OW:0] pitch_ext;
    logic signed [OW:0] plim;
    logic signed [OW:0] aroll;

    tafc_apb u_apb (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .limits(limits)
    );

    assign en = !out_vld_reg || result_out.ready;
    assign item_in.ready = en;

    assign yin_x[0] = W'($signed({item_in.data.right_x, 8'h00}));
    assign yin_y[0] = W'($signed({item_in.data.right_y, 8'h00}));
    assign yin_x[1] = W'($signed({item_in.data.up_x, 8'h00}));
    assign yin_y[1] = W'($signed({item_in.data.up_y, 8'h00}));
    assign yin_x[2] = W'($signed({item_in.data.fwd_x, 8'h00}));
    assign yin_y[2] = W'($signed({item_in.data.fwd_y, 8'h00}));

    tafc_cordic #(.STEPS(NS), .NV(3)) u_yaw (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(item_in.valid),
        .in_x(yin_x), .in_y(yin_y), .out_valid(y_vld),
        .out_x(y_x), .out_y(y_y), .out_z(y_z)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rz_dly_reg[0] <= {item_in.data.right_z, 8'h00};
            for (int i = 1; i <= NS; i++)
                rz_dly_reg[i] <= rz_dly_reg[i-1];
        end
    end

    // gain multiply for pitch; hold roll operands alongside
    assign nrz = -$signed({rz_dly_reg[NS][23], rz_dly_reg[NS]});
    assign prod = PW'(nrz) * PW'(tafc_pkg::GAIN_Q16);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_vld_reg <= 1'b0;
        else if (en)
            m_vld_reg <= y_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= y_x[0];
            py_reg <= W'(prod >>> 16);
            qx_reg <= y_y[1];
            qy_reg <= -y_y[2];
            yaw_m_reg <= tafc_pkg::to_out(y_z);
        end
    end

    assign pin_x[0] = px_reg;
    assign pin_y[0] = py_reg;
    assign rin_x[0] = qx_reg;
    assign rin_y[0] = qy_reg;

    tafc_cordic #(.STEPS(NS), .NV(1)) u_pitch (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(m_vld_reg),
        .in_x(pin_x), .in_y(pin_y), .out_valid(p_vld),
        .out_x(p_x), .out_y(p_y), .out_z(p_z)
    );

    tafc_cordic #(.STEPS(NS), .NV(1)) u_roll (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(m_vld_reg),
        .in_x(rin_x), .in_y(rin_y), .out_valid(r_vld),
        .out_x(r_x), .out_y(r_y), .out_z(r_z)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yaw_dly_reg[0] <= yaw_m_reg;
            for (int i = 1; i <= NS; i++)
                yaw_dly_reg[i] <= yaw_dly_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else if (en)
            a_vld_reg <= p_vld && r_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yaw_a_reg <= yaw_dly_reg[NS];
            pitch_a_reg <= tafc_pkg::to_out(p_z);
            roll_a_reg <= tafc_pkg::to_out(r_z);
        end
    end

    assign pitch_ext = {pitch_a_reg[OW-1], pitch_a_reg};
    assign plim = $signed({2'b00, limits.pitch_fall_limit});
    assign aroll = roll_a_reg[OW-1] ? -$signed({roll_a_reg[OW-1], roll_a_reg})
                                    : $signed({roll_a_reg[OW-1], roll_a_reg});

    always_comb
    begin
        out_next.yaw_angle = yaw_a_reg;
        out_next.pitch_angle = pitch_a_reg;
        out_next.roll_angle = roll_a_reg;
        out_next.on_back = pitch_ext < -plim;
        out_next.on_belly = pitch_ext > plim;
        out_next.on_side = aroll > $signed({2'b00, limits.roll_fall_limit});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= a_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_next;
    end

    assign result_out.valid = out_vld_reg;
    assign result_out.data = out_reg;

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> !(out_reg.on_back && out_reg.on_belly))
        else $error("back and belly flagged together");

    a_side_needs_roll: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_reg.on_side) |-> (out_reg.roll_angle != '0))
        else $error("side flagged with zero roll");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(a_vld_reg) && $stable(pitch_a_reg) && $stable(m_vld_reg))
        else $error("pipeline moved during stall");
endmodule
`default_nettype wire

// ===== tb/tb_classifier_board.sv =====
// Scoreboard for the torso attitude classifier: predicts angles and fall flags
// from each accepted rotation matrix and checks every output transfer.
// Depends on tafc_pkg.
package tb_classifier_board;

    class attitude_board;
        tafc_pkg::out_item_t pending[$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned pitch_lim;
        int unsigned roll_lim;
        int steps;

        function new();
            mismatches = 0;
            checked = 0;
            pitch_lim = 7680;
            roll_lim = 7680;
            steps = 16;
        endfunction

        static function longint floor_shift(longint v, int n);
            return v >>> n;
        endfunction

        static function longint atan_step(int i);
            longint tbl[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                57, 29, 14, 7, 4, 2, 1, 0};
            return tbl[i];
        endfunction

        function longint vector_angle(ref longint xs[3], ref longint ys[3], input int cnt);
            longint z;
            longint tx;
            longint ty;
            bit cw;
            z = 0;
            if (xs[0] == 0 && ys[0] == 0)
                return 0;
            if (xs[0] < 0)
            begin
                z = (ys[0] >= 0) ? 64'sd11796480 : -64'sd11796480;
                for (int k = 0; k < cnt; k++)
                begin
                    xs[k] = -xs[k];
                    ys[k] = -ys[k];
                end
            end
            for (int i = 0; i < steps && i < 24; i++)
            begin
                cw = ys[0] >= 0;
                for (int k = 0; k < cnt; k++)
                begin
                    tx = floor_shift(ys[k], i);
                    ty = floor_shift(xs[k], i);
                    if (cw)
                    begin
                        xs[k] += tx;
                        ys[k] -= ty;
                    end
                    else
                    begin
                        xs[k] -= tx;
                        ys[k] += ty;
                    end
                end
                z += cw ? atan_step(i) : -atan_step(i);
            end
            return z;
        endfunction

        static function longint to_units(longint z);
            longint a;
            a = floor_shift(z + 256, 9);
            if (a > 23040)
                a = 23040;
            if (a < -23040)
                a = -23040;
            return a;
        endfunction

        function void note_matrix(tafc_pkg::in_item_t m);
            longint xs[3];
            longint ys[3];
            longint rz;
            longint yaw;
            longint pitch;
            longint roll;
            longint aroll;
            tafc_pkg::out_item_t e;
            xs[0] = longint'(m.right_x) * 256;
            ys[0] = longint'(m.right_y) * 256;
            rz = longint'(m.right_z) * 256;
            xs[1] = longint'(m.up_x) * 256;
            ys[1] = longint'(m.up_y) * 256;
            xs[2] = longint'(m.fwd_x) * 256;
            ys[2] = longint'(m.fwd_y) * 256;
            yaw = to_units(vector_angle(xs, ys, 3));
            begin
                longint px[3];
                longint py[3];
                longint qx[3];
                longint qy[3];
                px = '{xs[0], 0, 0};
                py = '{floor_shift(-rz * 107922, 16), 0, 0};
                pitch = to_units(vector_angle(px, py, 1));
                qx = '{ys[1], 0, 0};
                qy = '{-ys[2], 0, 0};
                roll = to_units(vector_angle(qx, qy, 1));
            end
            aroll = roll < 0 ? -roll : roll;
            e.yaw_angle = yaw[15:0];
            e.pitch_angle = pitch[15:0];
            e.roll_angle = roll[15:0];
            e.on_back = pitch < -longint'(pitch_lim);
            e.on_belly = pitch > longint'(pitch_lim);
            e.on_side = aroll > longint'(roll_lim);
            pending.push_back(e);
        endfunction

        function void check_angles(tafc_pkg::out_item_t got);
            tafc_pkg::out_item_t e;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer %p", got);
                return;
            end
            e = pending.pop_front();
            if (got !== e)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: expected %p got %p", checked, e, got);
            end
        endfunction
    endclass
endpackage

// ===== tb/testbench.sv =====
// Top-level testbench of torso_attitude_fall_classifier: APB limit writes,
// directed and random rotation matrices, random stalls on both channels.
// Depends on tafc_pkg, tafc_in_if, tafc_out_if, tb_classifier_board.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    int unsigned quiet_cycles = 0;
    int unsigned sent = 0;
    int idle_pct = 37;
    bit timed_out = 1'b0;
    tb_classifier_board::attitude_board board = new();

    tafc_in_if item_in();
    tafc_out_if result_out();

    torso_attitude_fall_classifier dut (
        .clk(clk), .rst_n(rst_n), .item_in(item_in.sink), .result_out(result_out.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        item_in.valid = 1'b0;
        item_in.data = '0;
        result_out.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_in.valid && item_in.ready)
                board.note_matrix(item_in.data);
            if (result_out.valid && result_out.ready)
                board.check_angles(result_out.data);
            if ((item_in.valid && item_in.ready) || (result_out.valid && result_out.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            result_out.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (quiet_cycles >= 20000 && !timed_out)
        begin
            timed_out = 1'b1;
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_limit(input logic [2:0] addr, input logic [14:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= {17'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == tafc_pkg::ADDR_PITCH_LIMIT)
            board.pitch_lim = val;
        else
            board.roll_lim = val;
    endtask

    task automatic send_matrix(input tafc_pkg::in_item_t m);
        while ($urandom_range(99) < idle_pct)
        begin
            item_in.valid <= 1'b0;
            @(posedge clk);
        end
        item_in.valid <= 1'b1;
        item_in.data <= m;
        @(posedge clk);
        while (!item_in.ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic drain();
        item_in.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic logic signed [15:0] rand_entry();
        int sel;
        sel = $urandom_range(99);
        if (sel < 8)
            return 16'(-16384 + 32768 * $urandom_range(1));
        if (sel < 12)
            return 16'($urandom);
        if (sel < 16)
            return 16'sd0;
        return 16'($signed($urandom_range(32768)) - 16384);
    endfunction

    function automatic tafc_pkg::in_item_t rand_matrix();
        tafc_pkg::in_item_t m;
        m.right_x = rand_entry();
        m.right_y = rand_entry();
        m.right_z = rand_entry();
        m.up_x = rand_entry();
        m.up_y = rand_entry();
        m.up_z = rand_entry();
        m.fwd_x = rand_entry();
        m.fwd_y = rand_entry();
        m.fwd_z = rand_entry();
        return m;
    endfunction

    function automatic tafc_pkg::in_item_t make_matrix(input int rx, ry, rz, ux, uy, fx, fy);
        tafc_pkg::in_item_t m;
        m = '{16'(rx), 16'(ry), 16'(rz), 16'(ux), 16'(uy), 16'sd0, 16'(fx), 16'(fy), 16'sd0};
        return m;
    endfunction

    initial
    begin
        logic [14:0] plim[4] = '{15'd0, 15'd23040, 15'd2000, 15'd32767};
        logic [14:0] rlim[4] = '{15'd23040, 15'd0, 15'd11520, 15'd32767};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        send_matrix(make_matrix(16384, 0, 0, 0, 16384, 0, 0));
        send_matrix(make_matrix(0, 0, 0, 0, 0, 0, 0));
        send_matrix(make_matrix(-16384, 0, 0, 0, -16384, 0, 0));
        send_matrix(make_matrix(-16384, 0, 16384, 16384, 0, 0, 16384));
        send_matrix(make_matrix(0, 16384, -16384, -16384, 0, 16384, 0));
        send_matrix(make_matrix(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
        send_matrix(make_matrix(32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_matrix(make_matrix(0, 0, 16384, 0, 16384, 0, 0));
        send_matrix(make_matrix(0, 0, -16384, 0, 0, 16384, 0));
        send_matrix(make_matrix(8192, 8192, -11585, 0, -16384, -16384, 0));
        send_matrix(make_matrix(-1, 0, 1, -1, 0, 0, 1));
        send_matrix(make_matrix(-16384, -1, 0, 0, 0, 0, -16384));
        send_matrix('1);
        send_matrix('0);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            write_limit(tafc_pkg::ADDR_PITCH_LIMIT, plim[phase]);
            write_limit(tafc_pkg::ADDR_ROLL_LIMIT, rlim[phase]);
            idle_pct = (phase == 1) ? 0 : 37;
            repeat (420)
                send_matrix(rand_matrix());
            drain();
        end

        write_limit(tafc_pkg::ADDR_PITCH_LIMIT, 15'd7680);
        write_limit(tafc_pkg::ADDR_ROLL_LIMIT, 15'd7680);
        idle_pct = 37;
        repeat (40)
            send_matrix(rand_matrix());
        drain();

        $display("sent %0d matrices, checked %0d results over five limit settings",
            sent, board.checked);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
        begin
            $display("%0d mismatches, %0d results missing", board.mismatches,
                board.pending.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
